// ===== rtl/spm_pkg.sv =====
package spm_pkg;

  localparam int OP_W     = 2;
  localparam int COEF_W   = 16;
  localparam int EXP_W    = 8;
  localparam int PCOEF_W  = 32;
  localparam int PEXP_W   = 9;

  // a multiply emits at most this many result terms, highest exponents first
  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_MULTIPLY    = 2'd2;

  typedef struct packed {
    logic ld_first;
    logic ld_second;
    logic mul;
    logic acc;
    logic tab_sweep;
    logic sweep_chk;
    logic init_step;
    logic flush;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic first_empty;
    logic second_empty;
    logic last_pair;
    logic slot_zero;
    logic adv_ok;
    logic flush_done;
  } status_t;

endpackage

// ===== rtl/spm_ram.sv =====
module spm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/spm_datapath.sv =====
module spm_datapath
  import spm_pkg::*;
#(
  parameter int MAX_TERMS = 8,
  parameter int MAX_EXP   = 255
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  input  logic signed [COEF_W-1:0]  term_coef_i,
  input  logic [EXP_W-1:0]          term_exp_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [PCOEF_W-1:0] prod_coef_o,
  output logic [PEXP_W-1:0]         prod_exp_o,
  output logic                      last_term_o,
  output logic                      terms_dropped_o
);

  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int TERM_W    = COEF_W + EXP_W;
  localparam int TAB_DEPTH = 2 * MAX_EXP + 1;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);
  localparam int TAB_W     = PCOEF_W + 1;
  localparam logic [TAB_AW-1:0] TAB_TOP = TAB_AW'(TAB_DEPTH - 1);

  // term stores
  logic [CNT_W-1:0]  first_cnt_q, second_cnt_q;
  logic              ovf_q;
  logic              exp_bad, first_full, second_full;
  logic              first_we, second_we, ovf_set;
  logic [TERM_W-1:0] term_wdata, first_rdata, second_rdata;

  // pair walk
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
  logic             i_last, j_last;

  // product and exponent table
  logic signed [COEF_W-1:0]  a_coef, b_coef;
  logic signed [PCOEF_W-1:0] prod_d;
  logic [PCOEF_W-1:0]        prod_q;
  logic [PEXP_W-1:0]         e_sum;
  logic [TAB_AW-1:0]         e_addr, e_q;
  logic [TAB_AW-1:0]         tab_raddr, tab_waddr;
  logic [TAB_W-1:0]          tab_wdata, tab_rdata;
  logic                      tab_we;

  // sweep
  logic [TAB_AW-1:0]  k_q, k_d;
  logic               k_step, present, capture, can_push, adv_ok, sweep_adv;
  logic [RES_W-1:0]   n_q;
  logic               pend_valid_q;
  logic [PCOEF_W-1:0] pend_coef_q;
  logic [PEXP_W-1:0]  pend_exp_q;
  logic               push_mid, push_last, push;

  // output register
  logic               out_valid_q;
  logic [PCOEF_W-1:0] out_coef_q;
  logic [PEXP_W-1:0]  out_exp_q;
  logic               out_last_q, out_drop_q;

  assign exp_bad     = int'(term_exp_i) > MAX_EXP;
  assign first_full  = first_cnt_q == CNT_W'(MAX_TERMS);
  assign second_full = second_cnt_q == CNT_W'(MAX_TERMS);
  assign first_we    = cmd_i.ld_first && !first_full && !exp_bad;
  assign second_we   = cmd_i.ld_second && !second_full && !exp_bad;
  assign ovf_set     = (cmd_i.ld_first && (first_full || exp_bad)) ||
                       (cmd_i.ld_second && (second_full || exp_bad));
  assign term_wdata  = {term_coef_i, term_exp_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      ovf_q        <= 1'b0;
    end else if (cmd_i.finish) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      ovf_q        <= 1'b0;
    end else begin
      if (first_we) begin
        first_cnt_q <= first_cnt_q + CNT_W'(1);
      end
      if (second_we) begin
        second_cnt_q <= second_cnt_q + CNT_W'(1);
      end
      if (ovf_set) begin
        ovf_q <= 1'b1;
      end
    end
  end

  // read address is the next pair index so read data tracks i_q / j_q
  assign i_last = (CNT_W'(i_q) + CNT_W'(1)) == first_cnt_q;
  assign j_last = (CNT_W'(j_q) + CNT_W'(1)) == second_cnt_q;

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (cmd_i.acc) begin
      if (j_last) begin
        j_d = '0;
        i_d = i_last ? '0 : i_q + IDX_W'(1);
      end else begin
        j_d = j_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else begin
      i_q <= i_d;
      j_q <= j_d;
    end
  end

  spm_ram #(
    .WIDTH (TERM_W),
    .DEPTH (MAX_TERMS),
    .AW    (IDX_W)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (first_we),
    .waddr_i (first_cnt_q[IDX_W-1:0]),
    .wdata_i (term_wdata),
    .raddr_i (i_d),
    .rdata_o (first_rdata)
  );

  spm_ram #(
    .WIDTH (TERM_W),
    .DEPTH (MAX_TERMS),
    .AW    (IDX_W)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (second_we),
    .waddr_i (second_cnt_q[IDX_W-1:0]),
    .wdata_i (term_wdata),
    .raddr_i (j_d),
    .rdata_o (second_rdata)
  );

  assign a_coef = signed'(first_rdata[TERM_W-1:EXP_W]);
  assign b_coef = signed'(second_rdata[TERM_W-1:EXP_W]);
  assign prod_d = a_coef * b_coef;
  assign e_sum  = PEXP_W'(first_rdata[EXP_W-1:0]) + PEXP_W'(second_rdata[EXP_W-1:0]);
  assign e_addr = TAB_AW'(e_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_d;
      e_q    <= e_addr;
    end
  end

  // sweep: one slot per read/check pair, zeroing each slot as it moves on
  assign present   = tab_rdata[TAB_W-1];
  assign capture   = present && (n_q != RES_W'(MAX_RESULTS));
  assign can_push  = !out_valid_q || !out_stall_i;
  assign adv_ok    = !(capture && pend_valid_q && !can_push);
  assign sweep_adv = cmd_i.sweep_chk && adv_ok;
  assign k_step    = cmd_i.init_step || sweep_adv;
  assign k_d       = (k_q == '0) ? TAB_TOP : k_q - TAB_AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= TAB_TOP;
    end else if (k_step) begin
      k_q <= k_d;
    end
  end

  assign tab_raddr = cmd_i.tab_sweep ? k_q : e_addr;
  assign tab_we    = cmd_i.acc || k_step;
  assign tab_waddr = cmd_i.acc ? e_q : k_q;
  assign tab_wdata = cmd_i.acc ? {1'b1, tab_rdata[PCOEF_W-1:0] + prod_q} : '0;

  spm_ram #(
    .WIDTH (TAB_W),
    .DEPTH (TAB_DEPTH),
    .AW    (TAB_AW)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  // one term is held back so the final one can carry last_term
  assign push_mid  = sweep_adv && capture && pend_valid_q;
  assign push_last = cmd_i.flush && pend_valid_q && can_push;
  assign push      = push_mid || push_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      n_q          <= '0;
    end else if (cmd_i.finish) begin
      pend_valid_q <= 1'b0;
      n_q          <= '0;
    end else if (sweep_adv && capture) begin
      pend_valid_q <= 1'b1;
      n_q          <= n_q + RES_W'(1);
    end else if (push_last) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweep_adv && capture) begin
      pend_coef_q <= tab_rdata[PCOEF_W-1:0];
      pend_exp_q  <= PEXP_W'(k_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_coef_q <= pend_coef_q;
      out_exp_q  <= pend_exp_q;
      out_last_q <= push_last;
      out_drop_q <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign prod_coef_o     = signed'(out_coef_q);
  assign prod_exp_o      = out_exp_q;
  assign last_term_o     = out_last_q;
  assign terms_dropped_o = out_drop_q;

  assign status_o.first_empty  = first_cnt_q == '0;
  assign status_o.second_empty = second_cnt_q == '0;
  assign status_o.last_pair    = i_last && j_last;
  assign status_o.slot_zero    = k_q == '0;
  assign status_o.adv_ok       = adv_ok;
  assign status_o.flush_done   = !pend_valid_q || can_push;

  a_no_push_over_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !(out_valid_q && out_stall_i))
    else $error("result pushed over a held transaction");

  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= RES_W'(MAX_RESULTS))
    else $error("result count beyond cap");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (first_cnt_q == '0) && (second_cnt_q == '0) && !ovf_q && !pend_valid_q)
    else $error("job state not cleared after multiply");

endmodule

// ===== rtl/spm_ctrl.sv =====
module spm_ctrl
  import spm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [OP_W-1:0] op_i,
  input  status_t         status_i,
  output cmd_t            cmd_o
);

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_INIT   = 3'd0;
  localparam logic [STATE_W-1:0] ST_IDLE   = 3'd1;
  localparam logic [STATE_W-1:0] ST_MUL    = 3'd2;
  localparam logic [STATE_W-1:0] ST_ACC    = 3'd3;
  localparam logic [STATE_W-1:0] ST_SW_RD  = 3'd4;
  localparam logic [STATE_W-1:0] ST_SW_CHK = 3'd5;
  localparam logic [STATE_W-1:0] ST_FLUSH  = 3'd6;

  logic [STATE_W-1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (status_i.slot_zero) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (op_i)
            OP_LOAD_FIRST:  cmd_o.ld_first = 1'b1;
            OP_LOAD_SECOND: cmd_o.ld_second = 1'b1;
            OP_MULTIPLY: begin
              if (status_i.first_empty || status_i.second_empty) begin
                cmd_o.finish = 1'b1;
              end else begin
                state_d = ST_MUL;
              end
            end
            default: cmd_o = '0;
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = status_i.last_pair ? ST_SW_RD : ST_MUL;
      end
      ST_SW_RD: begin
        cmd_o.tab_sweep = 1'b1;
        state_d         = ST_SW_CHK;
      end
      ST_SW_CHK: begin
        cmd_o.tab_sweep = 1'b1;
        cmd_o.sweep_chk = 1'b1;
        if (status_i.adv_ok) begin
          state_d = status_i.slot_zero ? ST_FLUSH : ST_SW_RD;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (status_i.flush_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_acc_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |=> (state_q == ST_MUL) || (state_q == ST_SW_RD))
    else $error("accumulate step left to an unexpected state");

endmodule

// ===== rtl/sparse_polynomial_multiplier_unit.sv =====
// Sparse polynomial multiplier. Load transactions (op 0 / op 1) store one term of the
// first or second polynomial; a term past MAX_TERMS or with an exponent above MAX_EXP
// is dropped and raises terms_dropped on the next multiply's results. A multiply
// transaction (op 2) runs the pairwise products through one 16x16 multiplier and a
// read-modify-write of the exponent table RAM, then sweeps all 2*MAX_EXP+1 table
// slots from the top, emitting one result per exponent that occurred (at most 64,
// descending, last one flagged) and clearing each slot behind it. The input stalls
// while a multiply runs. If either polynomial is empty the multiply emits nothing.
// After reset the table is cleared with the input stalled. Op code 3 is accepted
// and ignored.
module sparse_polynomial_multiplier_unit
  import spm_pkg::*;
#(
  parameter int MAX_TERMS = 8,
  parameter int MAX_EXP   = 255
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [OP_W-1:0]           op_i,
  input  logic signed [COEF_W-1:0]  term_coef_i,
  input  logic [EXP_W-1:0]          term_exp_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [PCOEF_W-1:0] prod_coef_o,
  output logic [PEXP_W-1:0]         prod_exp_o,
  output logic                      last_term_o,
  output logic                      terms_dropped_o
);

  cmd_t    cmd;
  status_t status;

  spm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spm_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .MAX_EXP   (MAX_EXP)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .term_coef_i     (term_coef_i),
    .term_exp_i      (term_exp_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .prod_coef_o     (prod_coef_o),
    .prod_exp_o      (prod_exp_o),
    .last_term_o     (last_term_o),
    .terms_dropped_o (terms_dropped_o)
  );

endmodule

// ===== test/spm_product_check.sv =====
module spm_product_check
  import spm_pkg::*;
#(
  parameter int MAX_TERMS = 8,
  parameter int MAX_EXP   = 255
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [OP_W-1:0]           op_i,
  input  logic signed [COEF_W-1:0]  term_coef_i,
  input  logic [EXP_W-1:0]          term_exp_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [PCOEF_W-1:0] prod_coef_i,
  input  logic [PEXP_W-1:0]         prod_exp_i,
  input  logic                      last_term_i,
  input  logic                      terms_dropped_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam int SLOTS = 2 * MAX_EXP + 1;

  typedef struct {
    logic signed [PCOEF_W-1:0] coef;
    logic [PEXP_W-1:0]         exp;
    logic                      last_flag;
    logic                      dropped;
  } result_term_t;

  // index 0: first polynomial, index 1: second polynomial
  logic signed [COEF_W-1:0] coef_mem [2][MAX_TERMS];
  logic [EXP_W-1:0]         exp_mem  [2][MAX_TERMS];
  int                       term_cnt [2];
  bit                       drop_flag;
  int                       sel;
  result_term_t             expected_terms [$];

  task automatic predict_products();
    bit [PCOEF_W-1:0]          slot_sum  [SLOTS];
    bit                        slot_used [SLOTS];
    logic signed [PCOEF_W-1:0] prod;
    result_term_t              t;
    int                        e;
    int                        found;
    int                        emitted;
    int                        n;
    for (int a = 0; a < term_cnt[0]; a++) begin
      for (int b = 0; b < term_cnt[1]; b++) begin
        e = int'(exp_mem[0][a]) + int'(exp_mem[1][b]);
        prod = coef_mem[0][a] * coef_mem[1][b];
        slot_sum[e] += prod;
        slot_used[e] = 1'b1;
      end
    end
    found = 0;
    for (int k = 0; k < SLOTS; k++) begin
      if (slot_used[k]) found++;
    end
    emitted = (found < MAX_RESULTS) ? found : MAX_RESULTS;
    n = 0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (slot_used[k] && n < emitted) begin
        t.coef      = slot_sum[k];
        t.exp       = PEXP_W'(k);
        t.last_flag = (n == emitted - 1);
        t.dropped   = drop_flag;
        expected_terms.push_back(t);
        n++;
      end
    end
    term_cnt[0] = 0;
    term_cnt[1] = 0;
    drop_flag   = 1'b0;
  endtask

  task automatic compare_term();
    result_term_t want;
    if (expected_terms.size() == 0) begin
      $error("unexpected result transaction: prod_coef %0d prod_exp %0d",
             prod_coef_i, prod_exp_i);
      fail_count_o++;
    end else begin
      want = expected_terms.pop_front();
      if (prod_coef_i !== want.coef) begin
        $error("prod_coef mismatch: expected %0d, actual %0d", want.coef, prod_coef_i);
        fail_count_o++;
      end
      if (prod_exp_i !== want.exp) begin
        $error("prod_exp mismatch: expected %0d, actual %0d", want.exp, prod_exp_i);
        fail_count_o++;
      end
      if (last_term_i !== want.last_flag) begin
        $error("last_term mismatch: expected %0d, actual %0d", want.last_flag, last_term_i);
        fail_count_o++;
      end
      if (terms_dropped_i !== want.dropped) begin
        $error("terms_dropped mismatch: expected %0d, actual %0d",
               want.dropped, terms_dropped_i);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_cnt[0]  = 0;
      term_cnt[1]  = 0;
      drop_flag    = 1'b0;
      expected_terms.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        case (op_i)
          OP_LOAD_FIRST, OP_LOAD_SECOND: begin
            sel = int'(op_i == OP_LOAD_SECOND);
            if (term_cnt[sel] >= MAX_TERMS || term_exp_i > MAX_EXP) begin
              drop_flag = 1'b1;
            end else begin
              coef_mem[sel][term_cnt[sel]] = term_coef_i;
              exp_mem[sel][term_cnt[sel]]  = term_exp_i;
              term_cnt[sel]++;
            end
          end
          OP_MULTIPLY: begin
            predict_products();
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) compare_term();
      pending_o = expected_terms.size();
    end
  end

endmodule

// ===== test/tb.sv =====
module tb;
  import spm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DIRECTED_ITEMS = 20;
  localparam int RANDOM_ITEMS   = 500;
  localparam int DRAIN_CYCLES   = 1200;
  localparam int IDLE_LIMIT     = 20000;
  localparam int MAX_TERMS_TB   = 8;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [OP_W-1:0]           op;
  logic signed [COEF_W-1:0]  term_coef;
  logic [EXP_W-1:0]          term_exp;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [PCOEF_W-1:0] prod_coef;
  logic [PEXP_W-1:0]         prod_exp;
  logic                      last_term;
  logic                      terms_dropped;
  logic                      calm = 1'b0;
  int                        fail_count;
  int                        pending;
  int                        items_sent;
  int                        quiet_cycles;
  int                        job;

  sparse_polynomial_multiplier_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .term_coef_i    (term_coef),
    .term_exp_i     (term_exp),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .prod_coef_o    (prod_coef),
    .prod_exp_o     (prod_exp),
    .last_term_o    (last_term),
    .terms_dropped_o(terms_dropped)
  );

  spm_product_check product_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .op_i           (op),
    .term_coef_i    (term_coef),
    .term_exp_i     (term_exp),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .prod_coef_i    (prod_coef),
    .prod_exp_i     (prod_exp),
    .last_term_i    (last_term),
    .terms_dropped_i(terms_dropped),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 38);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op_sel, input logic signed [COEF_W-1:0] c,
                           input logic [EXP_W-1:0] e);
    bit taken;
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= op_sel;
    term_coef <= c;
    term_exp  <= e;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    if (op_sel != OP_UNUSED) items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // mostly 1 to MAX_TERMS_TB terms per store, now and then empty or overfilled stores
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(MAX_TERMS_TB + 1, MAX_TERMS_TB + 3);
    return $urandom_range(1, MAX_TERMS_TB);
  endfunction

  function automatic logic [EXP_W-1:0] term_exponent(input int style, input int idx,
                                                     input bit second);
    case (style)
      0: return EXP_W'($urandom_range(0, 255));
      1: return EXP_W'($urandom_range(0, 7));
      2: return second ? EXP_W'(idx * 8) : EXP_W'(idx);
      3: return EXP_W'($urandom_range(248, 255));
      default: return '0;
    endcase
  endfunction

  task automatic run_job();
    int                       n1;
    int                       n2;
    int                       i1;
    int                       i2;
    int                       xs;
    int                       cs;
    logic [OP_W-1:0]          op_sel;
    logic signed [COEF_W-1:0] c;
    logic [EXP_W-1:0]         e;
    n1 = pick_count();
    n2 = pick_count();
    xs = $urandom_range(0, 4);
    cs = $urandom_range(0, 3);
    i1 = 0;
    i2 = 0;
    while (i1 < n1 || i2 < n2) begin
      if (i1 < n1 && (i2 >= n2 || $urandom_range(0, 1))) begin
        op_sel = OP_LOAD_FIRST;
        e = term_exponent(xs, i1, 1'b0);
        i1++;
      end else begin
        op_sel = OP_LOAD_SECOND;
        e = term_exponent(xs, i2, 1'b1);
        i2++;
      end
      case (cs)
        0: c = COEF_W'($urandom);
        1: begin
          case ($urandom_range(0, 4))
            0: c = -16'sd32768;
            1: c = 16'sd32767;
            2: c = -16'sd1;
            3: c = 16'sd0;
            default: c = 16'sd1;
          endcase
        end
        2: c = -16'sd32768;
        default: c = COEF_W'($urandom_range(0, 6) - 3);
      endcase
      send_item(op_sel, c, e);
      if ($urandom_range(0, 29) == 0) begin
        send_item(OP_UNUSED, COEF_W'($urandom), EXP_W'($urandom));
      end
    end
    send_item(OP_MULTIPLY, COEF_W'($urandom), EXP_W'($urandom));
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    op         <= OP_LOAD_FIRST;
    term_coef  <= '0;
    term_exp   <= '0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // both stores empty, then second store empty
    send_item(OP_MULTIPLY, 16'sd0, 8'd0);
    send_item(OP_LOAD_FIRST, 16'sd32767, 8'd0);
    send_item(OP_MULTIPLY, 16'sd0, 8'd0);
    // extreme coefficients and exponents, zero-sum terms, unused op
    send_item(OP_LOAD_FIRST, -16'sd32768, 8'd255);
    send_item(OP_LOAD_SECOND, -16'sd32768, 8'd255);
    send_item(OP_UNUSED, -16'sd1, 8'd255);
    send_item(OP_LOAD_FIRST, 16'sd32767, 8'd0);
    send_item(OP_LOAD_SECOND, -16'sd1, 8'd0);
    send_item(OP_LOAD_SECOND, 16'sd0, 8'd128);
    send_item(OP_MULTIPLY, 16'sd0, 8'd0);
    // store full: ninth load dropped
    for (int i = 0; i <= MAX_TERMS_TB; i++) begin
      send_item(OP_LOAD_FIRST, COEF_W'(i + 1), EXP_W'(i));
    end
    send_item(OP_LOAD_SECOND, 16'sd1, 8'd0);
    send_item(OP_MULTIPLY, 16'sd0, 8'd0);
    wait_drain();

    job = 0;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      calm <= (job >= 15 && job < 25);
      run_job();
      if (job % 8 == 7) wait_drain();
      job++;
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
